>>> rtl/core/rdsr_pkg.sv
// Shared types and constants for the RRIP dueling stream replacement unit.
// No dependencies; used by the front, back and top level files.
package rdsr_pkg;

   localparam int SETS         = 2048;
   localparam int WAYS         = 16;
   localparam int LEADER_SETS  = 64;
   localparam int SELECTOR_MAX = 1023;

   localparam int SET_W  = 11;
   localparam int WAY_W  = 4;
   localparam int ADDR_W = 64;
   localparam int SEL_W  = 10;
   localparam int LFSR_W = 16;

   localparam logic [SEL_W-1:0]  SEL_MID   = SEL_W'(SELECTOR_MAX / 2);
   localparam logic [SEL_W-1:0]  SEL_TOP   = SEL_W'(SELECTOR_MAX);
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [1:0]        RRPV_MAX  = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_STREAM_WINDOW = 2'd0;
   localparam logic [1:0] CSR_BYPASS_SCORE  = 2'd1;
   localparam logic [1:0] CSR_BIP_RATE_LOG2 = 2'd2;
   localparam logic [1:0] CSR_RNG_SEED      = 2'd3;

   // Action codes
   localparam logic ACT_VICTIM = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   // Set classes for dueling
   localparam logic [1:0] CLS_LIP    = 2'd0;
   localparam logic [1:0] CLS_BIP    = 2'd1;
   localparam logic [1:0] CLS_FOLLOW = 2'd2;

   typedef struct packed {
      logic              action;
      logic [SET_W-1:0]  set_idx;
      logic [1:0]        set_class;
      logic [WAY_W-1:0]  way;
      logic [WAYS-1:0]   valid_mask;
      logic [ADDR_W-1:0] address;
      logic              was_hit;
   } item_type;

   // Front to back: queue head
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // Back to front: pop and clearing status
   typedef struct packed {
      logic pop;
      logic busy;
   } back_stat_type;

endpackage

>>> rtl/core/rrip_dueling_stream_replacement_unit.sv
// A beat is queued; on issue its set row is read into a register; on execute the row is
// modified and written back and the response is registered. One beat is handled at a time.
// Reset: synchronous; a clearing pass over all 2048 sets then initializes the set
// memories, with req_stall high; csr writes are taken throughout.
// Depends on rdsr_pkg, rdsr_front and rdsr_back.
module rrip_dueling_stream_replacement_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [10:0] req_set_index,
   input  logic [3:0]  req_way_index,
   input  logic [15:0] req_valid_mask,
   input  logic [63:0] req_address,
   input  logic        req_was_hit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_victim_way,
   output logic [1:0]  rsp_new_rrpv
);

   rdsr_pkg::head_type      head;
   rdsr_pkg::back_stat_type stat;

   rdsr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_set_index  (req_set_index),
      .req_way_index  (req_way_index),
      .req_valid_mask (req_valid_mask),
      .req_address    (req_address),
      .req_was_hit    (req_was_hit),
      .stat           (stat),
      .head           (head)
   );

   rdsr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .head           (head),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_victim_way (rsp_victim_way),
      .rsp_new_rrpv   (rsp_new_rrpv)
   );

endmodule

>>> rtl/core/rdsr_front.sv
// Front part: accepts request beats, classifies the set, and queues them.
// Depends on rdsr_pkg.
module rdsr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [10:0]               req_set_index,
   input  logic [3:0]                req_way_index,
   input  logic [15:0]               req_valid_mask,
   input  logic [63:0]               req_address,
   input  logic                      req_was_hit,
   input  rdsr_pkg::back_stat_type   stat,
   output rdsr_pkg::head_type        head
);

   rdsr_pkg::item_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   rdsr_pkg::item_type new_item;

   // Classify the incoming set
   always_comb begin
      new_item.action     = req_action;
      new_item.set_idx    = req_set_index;
      new_item.way        = req_way_index;
      new_item.valid_mask = req_valid_mask;
      new_item.address    = req_address;
      new_item.was_hit    = req_was_hit;
      if (req_set_index < rdsr_pkg::SET_W'(rdsr_pkg::LEADER_SETS)) begin
         new_item.set_class = rdsr_pkg::CLS_LIP;
      end else if (req_set_index < rdsr_pkg::SET_W'(2 * rdsr_pkg::LEADER_SETS)) begin
         new_item.set_class = rdsr_pkg::CLS_BIP;
      end else begin
         new_item.set_class = rdsr_pkg::CLS_FOLLOW;
      end
   end

   assign req_stall = (count_ff == 2'd2) || stat.busy;
   assign push      = req_valid && !req_stall;

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = stat.pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, stat.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

endmodule

>>> rtl/core/rdsr_back.sv
// Back part: set memories, clearing pass, victim search, stream detector,
// dueling selector and LFSR, config registers and the response register.
// Depends on rdsr_pkg.
module rdsr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   input  rdsr_pkg::head_type        head,
   output rdsr_pkg::back_stat_type   stat,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_victim_way,
   output logic [1:0]                rsp_new_rrpv
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   localparam int RROW_W = 2 * rdsr_pkg::WAYS;
   localparam int SROW_W = rdsr_pkg::ADDR_W + 2;

   logic [RROW_W-1:0] rrpv_mem [rdsr_pkg::SETS];
   logic [SROW_W-1:0] strm_mem [rdsr_pkg::SETS];

   logic [1:0]  state_ff, state_in;
   logic [rdsr_pkg::SET_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [RROW_W-1:0] rrow_ff;
   logic [SROW_W-1:0] srow_ff;

   logic [15:0] window_ff;
   logic [1:0]  bypass_ff;
   logic [3:0]  rate_ff;
   logic [rdsr_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [rdsr_pkg::SEL_W-1:0]  sel_ff, sel_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_way_ff;
   logic [1:0] rsp_rrpv_ff;

   logic issue, exec_go;
   rdsr_pkg::item_type it;

   assign it      = head.item;
   assign issue   = (state_ff == ST_IDLE) && head.valid;
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == rdsr_pkg::SET_W'(rdsr_pkg::SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (issue) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Victim search over the registered row
   logic [1:0] rv [rdsr_pkg::WAYS];
   logic       inv_found;
   logic [3:0] inv_way;
   logic       hi_any, lo_hi, lo_any;
   logic [1:0] top, inc;
   logic [3:0] top_way;
   logic [RROW_W-1:0] aged_row;

   always_comb begin
      inv_found = 1'b0;
      inv_way   = 4'd0;
      hi_any    = 1'b0;
      lo_hi     = 1'b0;
      lo_any    = 1'b0;
      top_way   = 4'd0;
      for (int w = 0; w < rdsr_pkg::WAYS; w++) begin
         rv[w]  = rrow_ff[2*w +: 2];
         hi_any = hi_any | rv[w][1];
         lo_hi  = lo_hi | (rv[w][1] & rv[w][0]);
         lo_any = lo_any | rv[w][0];
      end
      for (int w = rdsr_pkg::WAYS - 1; w >= 0; w--) begin
         if (!it.valid_mask[w]) begin
            inv_found = 1'b1;
            inv_way   = 4'(w);
         end
      end
      top = {hi_any, hi_any ? lo_hi : lo_any};
      inc = rdsr_pkg::RRPV_MAX - top;
      for (int w = rdsr_pkg::WAYS - 1; w >= 0; w--) begin
         if (rv[w] == top) begin
            top_way = 4'(w);
         end
      end
      for (int w = 0; w < rdsr_pkg::WAYS; w++) begin
         aged_row[2*w +: 2] = rv[w] + inc;
      end
   end

   // Stream detector
   logic [63:0] last, diff_a, diff_b, span;
   logic [1:0]  lvl, new_lvl;
   logic        streaming;

   always_comb begin
      last   = srow_ff[SROW_W-1:2];
      lvl    = srow_ff[1:0];
      diff_a = it.address - last;
      diff_b = last - it.address;
      if (last == 64'd0) begin
         span = 64'd0;
      end else if (it.address >= last) begin
         span = diff_a;
      end else begin
         span = diff_b;
      end
      streaming = (span != 64'd0) && (span[63:16] == 48'd0) && (span[15:0] <= window_ff);
      if (streaming) begin
         new_lvl = (lvl == 2'd3) ? lvl : lvl + 2'd1;
      end else begin
         new_lvl = (lvl == 2'd0) ? lvl : lvl - 2'd1;
      end
   end

   // Insertion choice
   logic [15:0] lfsr_step, bip_mask;
   logic [1:0]  bip_val, ins_val;
   logic        use_bip;

   always_comb begin
      lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? rdsr_pkg::LFSR_TAPS : 16'd0);
      bip_mask  = (16'd1 << rate_ff) - 16'd1;
      bip_val   = ((lfsr_step & bip_mask) == 16'd0) ? 2'd1 : rdsr_pkg::RRPV_MAX;
      use_bip   = 1'b0;
      sel_in    = sel_ff;
      ins_val   = rdsr_pkg::RRPV_MAX;
      if (it.was_hit) begin
         ins_val = 2'd0;
      end else if (new_lvl >= bypass_ff) begin
         ins_val = rdsr_pkg::RRPV_MAX;
      end else begin
         case (it.set_class)
            rdsr_pkg::CLS_LIP: begin
               if (sel_ff != '0) sel_in = sel_ff - 1'b1;
            end
            rdsr_pkg::CLS_BIP: begin
               use_bip = 1'b1;
               ins_val = bip_val;
               if (sel_ff != rdsr_pkg::SEL_TOP) sel_in = sel_ff + 1'b1;
            end
            default: begin
               if (sel_ff < rdsr_pkg::SEL_MID) begin
                  use_bip = 1'b1;
                  ins_val = bip_val;
               end
            end
         endcase
      end
      if (csr_write_en && (csr_index == rdsr_pkg::CSR_RNG_SEED)) begin
         lfsr_in = (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
      end else if (exec_go && (it.action == rdsr_pkg::ACT_UPDATE) && use_bip) begin
         lfsr_in = lfsr_step;
      end else begin
         lfsr_in = lfsr_ff;
      end
   end

   // Updated row for an access
   logic [RROW_W-1:0] upd_row;
   always_comb begin
      upd_row = rrow_ff;
      upd_row[{it.way, 1'b0} +: 2] = ins_val;
   end

   // Response register
   always_comb begin
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= rdsr_pkg::SEL_MID;
         lfsr_ff      <= 16'd1;
         window_ff    <= 16'd128;
         bypass_ff    <= 2'd2;
         rate_ff      <= 4'd5;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         lfsr_ff      <= lfsr_in;
         if (exec_go && (it.action == rdsr_pkg::ACT_UPDATE)) begin
            sel_ff <= sel_in;
         end
         if (csr_write_en) begin
            case (csr_index)
               rdsr_pkg::CSR_STREAM_WINDOW: window_ff <= csr_wdata;
               rdsr_pkg::CSR_BYPASS_SCORE:  bypass_ff <= csr_wdata[1:0];
               rdsr_pkg::CSR_BIP_RATE_LOG2: rate_ff   <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (exec_go) begin
         if (it.action == rdsr_pkg::ACT_VICTIM) begin
            rsp_way_ff  <= inv_found ? inv_way : top_way;
            rsp_rrpv_ff <= 2'd0;
         end else begin
            rsp_way_ff  <= 4'd0;
            rsp_rrpv_ff <= ins_val;
         end
      end
   end

   // Set memories: clearing pass, read on issue, write back on execute
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         rrpv_mem[clr_cnt_ff] <= '1;
         strm_mem[clr_cnt_ff] <= '0;
      end else if (exec_go) begin
         if (it.action == rdsr_pkg::ACT_VICTIM) begin
            if (!inv_found) rrpv_mem[it.set_idx] <= aged_row;
         end else begin
            rrpv_mem[it.set_idx] <= upd_row;
            strm_mem[it.set_idx] <= {it.address, new_lvl};
         end
      end
      if (issue) begin
         rrow_ff <= rrpv_mem[it.set_idx];
         srow_ff <= strm_mem[it.set_idx];
      end
   end

   assign stat.pop   = exec_go;
   assign stat.busy  = (state_ff == ST_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;
   assign rsp_new_rrpv   = rsp_rrpv_ff;

endmodule

>>> rtl/core/rdsr_checker.sv
// Port-level checks for the replacement unit, and the bind that attaches them.
// Depends on rrip_dueling_stream_replacement_unit.
module rdsr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_victim_way,
   input logic [1:0] rsp_new_rrpv
);

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_victim_way)
         && $stable(rsp_new_rrpv))
      else $error("stalled response changed");

   // A response is either a victim or an update, never both
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_victim_way == 4'd0) || (rsp_new_rrpv == 2'd0))
      else $error("response carries both victim and rrpv");

   // Request side is stalled right after reset, as the clearing pass starts
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

endmodule

bind rrip_dueling_stream_replacement_unit rdsr_checker u_rdsr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_victim_way (rsp_victim_way),
   .rsp_new_rrpv   (rsp_new_rrpv)
);

>>> sim/testbench.sv
// Self-checking testbench for rrip_dueling_stream_replacement_unit.
// A built-in predictor of the SRRIP, stream and set-dueling policy checks every beat.
// Depends on rdsr_pkg and the unit's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0] victim;
      logic [1:0] rrpv;
   } policy_result_type;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [10:0] req_set_index = '0;
   logic [3:0]  req_way_index = '0;
   logic [15:0] req_valid_mask = '0;
   logic [63:0] req_address = '0;
   logic        req_was_hit = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_victim_way;
   logic [1:0]  rsp_new_rrpv;

   rrip_dueling_stream_replacement_unit dut (.*);

   always #2 clock = ~clock;

   // Predictor state
   logic [1:0]                 rrpv_mem [rdsr_pkg::SETS][rdsr_pkg::WAYS];
   logic [63:0]                prev_addr [rdsr_pkg::SETS];
   logic [1:0]                 stream_lvl [rdsr_pkg::SETS];
   logic [rdsr_pkg::SEL_W-1:0] selector;
   logic [15:0]                lfsr;
   logic [15:0]                win_cfg;
   logic [1:0]                 bypass_cfg;
   logic [3:0]                 bip_log_cfg;

   policy_result_type expected_q[$];
   int errors = 0;
   int checked = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int victims_sent = 0;
   int updates_sent = 0;

   task automatic load_seed(input logic [15:0] seed);
      lfsr = (seed == 0) ? 16'd1 : seed;
   endtask

   // Step the LFSR and take the BIP decision
   function automatic logic [1:0] bip_insert();
      logic lsb;
      logic [15:0] mask;
      lsb = lfsr[0];
      mask = 16'((32'd1 << bip_log_cfg) - 1);
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ rdsr_pkg::LFSR_TAPS;
      return ((lfsr & mask) == 0) ? 2'd1 : rdsr_pkg::RRPV_MAX;
   endfunction

   function automatic logic [3:0] pick_victim(input int s, input logic [15:0] vmask);
      logic [1:0] top;
      top = 0;
      for (int w = 0; w < rdsr_pkg::WAYS; w++)
         if (!vmask[w]) return 4'(w);
      for (int w = 0; w < rdsr_pkg::WAYS; w++)
         if (rrpv_mem[s][w] > top) top = rrpv_mem[s][w];
      if (top < rdsr_pkg::RRPV_MAX)
         for (int w = 0; w < rdsr_pkg::WAYS; w++)
            rrpv_mem[s][w] = rrpv_mem[s][w] + (rdsr_pkg::RRPV_MAX - top);
      for (int w = 0; w < rdsr_pkg::WAYS; w++)
         if (rrpv_mem[s][w] == rdsr_pkg::RRPV_MAX) return 4'(w);
      return 4'd0;
   endfunction

   function automatic logic [1:0] insert_value(input int s, input int w,
                                               input logic [63:0] addr, input logic hit);
      logic [63:0] span;
      logic [1:0] v;
      span = 0;
      if (prev_addr[s] != 0)
         span = (addr >= prev_addr[s]) ? addr - prev_addr[s] : prev_addr[s] - addr;
      if (span > 0 && span <= {48'd0, win_cfg}) begin
         if (stream_lvl[s] < 3) stream_lvl[s]++;
      end else if (stream_lvl[s] > 0) begin
         stream_lvl[s]--;
      end
      prev_addr[s] = addr;
      if (hit) begin
         v = 0;
      end else if (stream_lvl[s] >= bypass_cfg) begin
         v = rdsr_pkg::RRPV_MAX;
      end else if (s < rdsr_pkg::LEADER_SETS) begin
         v = rdsr_pkg::RRPV_MAX;
         if (selector > 0) selector--;
      end else if (s < 2 * rdsr_pkg::LEADER_SETS) begin
         v = bip_insert();
         if (selector < rdsr_pkg::SEL_TOP) selector++;
      end else if (selector >= rdsr_pkg::SEL_MID) begin
         v = rdsr_pkg::RRPV_MAX;
      end else begin
         v = bip_insert();
      end
      if (w < rdsr_pkg::WAYS) rrpv_mem[s][w] = v;
      return v;
   endfunction

   task automatic predictor_reset();
      foreach (rrpv_mem[s, w]) rrpv_mem[s][w] = rdsr_pkg::RRPV_MAX;
      foreach (prev_addr[s]) begin
         prev_addr[s] = 0;
         stream_lvl[s] = 0;
      end
      selector = rdsr_pkg::SEL_MID;
      win_cfg = 16'd128;
      bypass_cfg = 2'd2;
      bip_log_cfg = 4'd5;
      load_seed(16'd1);
   endtask

   // One register write; the caller drops the write enable after the last one
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         rdsr_pkg::CSR_STREAM_WINDOW: win_cfg = val;
         rdsr_pkg::CSR_BYPASS_SCORE:  bypass_cfg = val[1:0];
         rdsr_pkg::CSR_BIP_RATE_LOG2: bip_log_cfg = val[3:0];
         rdsr_pkg::CSR_RNG_SEED:      load_seed(val);
         default: ;
      endcase
   endtask

   // Send one beat; predict at acceptance
   task automatic send_beat(input logic act, input logic [10:0] s, input logic [3:0] w,
                            input logic [15:0] vm, input logic [63:0] addr, input logic hit);
      policy_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_set_index <= s;
      req_way_index <= w;
      req_valid_mask <= vm;
      req_address <= addr;
      req_was_hit <= hit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = '0;
      if (act == rdsr_pkg::ACT_VICTIM) begin
         r.victim = pick_victim(int'(s), vm);
         victims_sent++;
      end else begin
         r.rrpv = insert_value(int'(s), int'(w), addr, hit);
         updates_sent++;
      end
      expected_q = {expected_q, r};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         policy_result_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: victim %0d rrpv %0d",
                                       rsp_victim_way, rsp_new_rrpv);
         end else begin
            exp_r = expected_q.pop_front();
            checked++;
            if (exp_r.victim !== rsp_victim_way || exp_r.rrpv !== rsp_new_rrpv) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: victim exp %0d got %0d, rrpv exp %0d got %0d",
                           exp_r.victim, rsp_victim_way, exp_r.rrpv, rsp_new_rrpv);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic logic [63:0] rand_addr();
      return {$urandom(), $urandom()};
   endfunction

   // Directed: field extremes, both actions, empty mask, full mask
   task automatic test_directed();
      send_beat(rdsr_pkg::ACT_VICTIM, 11'd0, 4'd0, 16'h0000, 64'd0, 1'b0);
      send_beat(rdsr_pkg::ACT_VICTIM, 11'd2047, 4'd15, 16'hFFFF, '1, 1'b1);
      send_beat(rdsr_pkg::ACT_VICTIM, 11'd5, 4'd0, 16'h7FFF, 64'd0, 1'b0);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd2047, 4'd15, 16'hFFFF, '1, 1'b1);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd2047, 4'd0, 16'h0, 64'd1, 1'b0);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd0, 4'd3, 16'h0, 64'h1000, 1'b0);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd0, 4'd3, 16'h0, 64'h1040, 1'b0);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd0, 4'd4, 16'h0, 64'h1080, 1'b0);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd0, 4'd5, 16'h0, 64'h1000, 1'b1);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd64, 4'd1, 16'h0, 64'h9000_0000, 1'b0);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd127, 4'd2, 16'h0, 64'h9100_0000, 1'b0);
      send_beat(rdsr_pkg::ACT_UPDATE, 11'd128, 4'd2, 16'h0, 64'hFFFF_0000, 1'b0);
      send_beat(rdsr_pkg::ACT_VICTIM, 11'd0, 4'd0, 16'hFFFF, 64'd0, 1'b0);
      send_beat(rdsr_pkg::ACT_VICTIM, 11'd0, 4'd0, 16'hFFFF, 64'd0, 1'b0);
      send_beat(rdsr_pkg::ACT_VICTIM, 11'd2047, 4'd0, 16'hFFFF, 64'd0, 1'b0);
      drain();
   endtask

   // Streams: runs of close addresses in few sets, with noise
   task automatic test_random(input int count, input int nsets);
      logic [10:0] s;
      logic [63:0] a;
      for (int i = 0; i < count; i++) begin
         s = 11'($urandom_range(nsets - 1));
         if ($urandom_range(3) == 0) s = 11'($urandom());
         if ($urandom_range(2) == 0) begin
            send_beat(rdsr_pkg::ACT_VICTIM, s, 4'($urandom()),
                      ($urandom_range(1) ? 16'hFFFF : 16'($urandom() | $urandom())),
                      rand_addr(), 1'($urandom()));
         end else begin
            a = ($urandom_range(4) == 0) ? rand_addr()
                : prev_addr[s] + 64'($urandom_range(300)) - 64'd100;
            send_beat(rdsr_pkg::ACT_UPDATE, s, 4'($urandom()), 16'($urandom()), a,
                      ($urandom_range(3) == 0));
         end
      end
      drain();
   endtask

   task automatic test_config(input logic [15:0] win, input logic [1:0] byp,
                              input logic [3:0] rate, input logic [15:0] seed);
      write_csr(rdsr_pkg::CSR_STREAM_WINDOW, win);
      write_csr(rdsr_pkg::CSR_BYPASS_SCORE, {14'd0, byp});
      write_csr(rdsr_pkg::CSR_BIP_RATE_LOG2, {12'd0, rate});
      write_csr(rdsr_pkg::CSR_RNG_SEED, seed);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      predictor_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      test_directed();
      test_random(200, 192);
      send_idle_pct = 49;
      test_config(16'd1, 2'd0, 4'd0, 16'd0);
      test_random(200, 192);
      send_idle_pct = 0;
      stall_pct = 49;
      test_config(16'hFFFF, 2'd3, 4'd15, 16'hFFFF);
      test_random(200, 256);
      send_idle_pct = 20;
      stall_pct = 20;
      test_config(16'd0, 2'd1, 4'd1, 16'hACE1);
      test_random(250, 192);
      send_idle_pct = 0;
      stall_pct = 0;
      test_config(16'd200, 2'd2, 4'd2, 16'd7);
      test_random(250, 2048);

      $display("covered %0d victim requests and %0d access updates, %0d beats checked",
               victims_sent, updates_sent, checked);
      $display("five register settings incl. extremes, four idle/stall mixes");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("%0d mismatches, %0d beats outstanding", errors, expected_q.size());
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
